>>> hw/rtl/pat_pkg.sv
package pat_pkg;

	localparam int CAPACITY = 16;
	localparam int POS_W    = 4;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

>>> hw/rtl/positional_array_table_top.sv
// Positional array table: a packed, ordered table of signed 32-bit entries
// with a fill count, driven by one request item at a time.
// Request channel: drive kind, position and value with start high; the item
// is taken at a rising edge where start is high and busy is low. Kinds are
// insert (later entries move up), update, delete (later entries move down)
// and read of one entry.
// Result channel: done is high for exactly one cycle with status, read_value
// and count. The receiver cannot stall; the result must be taken then.
// Timing: the accepting edge latches the request and enters execution; the
// next edge runs the shift across all cells in parallel, registers the
// result and raises done. No new item is taken while one executes; busy is
// high during the execute cycle.
// Status is done, invalid position (insert allows 0..count, the others
// 0..count-1) or table full on insert. A refused item leaves the table as is.
// Reset clears the fill count and the control state; entry contents are
// not cleared and are only ever read below the count.
module positional_array_table_top import pat_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               kind,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     busy,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         count
);

	cmd_t cmd;

	pat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	pat_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

endmodule

>>> hw/rtl/pat_ctrl.sv
module pat_ctrl import pat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   exec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			exec_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
						exec_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					exec_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					exec_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign cmd.load = start & ~busy_q;
	assign cmd.exec = exec_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && cmd.exec)
		else $error("accepted item did not enter execution");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done && !busy)
		else $error("execution did not produce a result strobe");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

endmodule

>>> hw/rtl/pat_dpath.sv
module pat_dpath import pat_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic [1:0]               kind,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         count
);

	kind_t                     kind_q;
	logic [POS_W-1:0]          pos_q;
	logic [DATA_W-1:0]         value_q;
	logic [CNT_W-1:0]          count_q;
	logic [DATA_W-1:0]         entries_q [CAPACITY];
	status_t                   status_q;
	logic [DATA_W-1:0]         read_value_q;

	logic [CNT_W-1:0] pos_ext;
	logic             pos_in_use;
	logic             pos_insert_ok;
	logic             full;
	logic             do_insert;
	logic             do_update;
	logic             do_delete;
	logic             do_read;
	status_t          status_next;

	assign pos_ext       = CNT_W'(pos_q);
	assign pos_in_use    = pos_ext < count_q;
	assign pos_insert_ok = pos_ext <= count_q;
	assign full          = count_q == CNT_W'(CAPACITY);

	always_comb begin
		do_insert   = 1'b0;
		do_update   = 1'b0;
		do_delete   = 1'b0;
		do_read     = 1'b0;
		status_next = ST_DONE;
		case (kind_q)
			KIND_INSERT: begin
				if (!pos_insert_ok) begin
					status_next = ST_BADPOS;
				end else if (full) begin
					status_next = ST_FULL;
				end else begin
					do_insert = 1'b1;
				end
			end
			KIND_UPDATE: begin
				if (!pos_in_use) status_next = ST_BADPOS;
				else do_update = 1'b1;
			end
			KIND_DELETE: begin
				if (!pos_in_use) status_next = ST_BADPOS;
				else do_delete = 1'b1;
			end
			default: begin
				if (!pos_in_use) status_next = ST_BADPOS;
				else do_read = 1'b1;
			end
		endcase
	end

	// Request and result registers hold payload only.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_t'(kind);
			pos_q   <= position;
			value_q <= value;
		end
		if (cmd.exec) begin
			status_q     <= status_next;
			read_value_q <= do_read ? entries_q[pos_q] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (do_insert) count_q <= count_q + 1'b1;
			else if (do_delete) count_q <= count_q - 1'b1;
		end
	end

	// Every cell looks only at itself and its two neighbors, so a whole shift
	// is done in the execute cycle. Cells above the count may take stale data.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if ((do_insert || do_update) && pos_q == POS_W'(i)) begin
					entries_q[i] <= value_q;
				end else if (do_insert && POS_W'(i) > pos_q) begin
					if (i > 0) entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
				end else if (do_delete && POS_W'(i) >= pos_q) begin
					if (i < CAPACITY - 1)
						entries_q[i] <= entries_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("fill count changed outside execution");

	a_full_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && full |=> count_q == CNT_W'(CAPACITY)
			|| count_q == CNT_W'(CAPACITY - 1))
		else $error("full table grew");

endmodule
